/* design/query_hit_payload_parser_core_assert.svh */
// assertion macros for the query-hit payload parser
`ifndef QUERY_HIT_PAYLOAD_PARSER_CORE_ASSERT_SVH
`define QUERY_HIT_PAYLOAD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define QHP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define QHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QHP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define QHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

/* design/qhp_pkg.sv */
// shared types, codes and defaults of the query-hit payload parser
`timescale 1ns / 1ps

package qhp_pkg;

    // defaults for the top-level parameters
    localparam int QHP_SERVENT_ID_BYTES = 16;
    localparam int QHP_MAX_STRING_BYTES = 255;
    localparam int QHP_LENGTH_BITS      = 16;

    // byte widths of the fixed fields
    localparam logic [8:0] FW_ONE  = 9'd1;
    localparam logic [8:0] FW_PORT = 9'd2;
    localparam logic [8:0] FW_WORD = 9'd4;

    // parser phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE   = 15'h0001,
        PH_HITS   = 15'h0002,
        PH_PORT   = 15'h0004,
        PH_ADDR   = 15'h0008,
        PH_SPEED  = 15'h0010,
        PH_INDEX  = 15'h0020,
        PH_SIZE   = 15'h0040,
        PH_NAME   = 15'h0080,
        PH_EXT    = 15'h0100,
        PH_VENDOR = 15'h0200,
        PH_OSIZE  = 15'h0400,
        PH_OPEN   = 15'h0800,
        PH_PRIV   = 15'h1000,
        PH_SERV   = 15'h2000,
        PH_END    = 15'h4000
    } qhp_phase_t;

    // field ids on the result channel
    localparam logic [3:0] FID_HITS     = 4'd0;
    localparam logic [3:0] FID_PORT     = 4'd1;
    localparam logic [3:0] FID_ADDR     = 4'd2;
    localparam logic [3:0] FID_SPEED    = 4'd3;
    localparam logic [3:0] FID_INDEX    = 4'd4;
    localparam logic [3:0] FID_SIZE     = 4'd5;
    localparam logic [3:0] FID_NAME     = 4'd6;
    localparam logic [3:0] FID_EXT      = 4'd7;
    localparam logic [3:0] FID_VENDOR   = 4'd8;
    localparam logic [3:0] FID_OSIZE    = 4'd9;
    localparam logic [3:0] FID_OPEN     = 4'd10;
    localparam logic [3:0] FID_PRIV     = 4'd11;
    localparam logic [3:0] FID_SERVENT  = 4'd12;

    // error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_STR_LONG = 2'd1;
    localparam logic [1:0] ERR_SHORT    = 2'd2;
    localparam logic [1:0] ERR_PAST_END = 2'd3;

    // parser context of fixed width
    typedef struct packed {
        qhp_phase_t  phase;
        logic [7:0]  field_byte_count;
        logic [7:0]  hits_left;
        logic [7:0]  hit_counter;
        logic [31:0] value_accumulator;
        logic [7:0]  open_data_left;
    } qhp_ctx_t;

    localparam qhp_ctx_t QHP_CTX_RESET = '{PH_IDLE, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0};

    // one result item
    typedef struct packed {
        logic [3:0]  field_id;
        logic [7:0]  byte_index;
        logic [7:0]  hit_number;
        logic [7:0]  data_byte;
        logic [31:0] field_value;
        logic        field_done;
        logic        message_done;
        logic [1:0]  error_code;
    } qhp_result_t;

endpackage

/* design/qhp_step.sv */
// per-byte parse step: next context and result item from one payload byte
`timescale 1ns / 1ps

module qhp_step import qhp_pkg::*; #(
    parameter int SERVENT_ID_BYTES = QHP_SERVENT_ID_BYTES,
    parameter int MAX_STRING_BYTES = QHP_MAX_STRING_BYTES,
    parameter int LENGTH_BITS      = QHP_LENGTH_BITS
) (
    input  logic [7:0]             payload_byte,
    input  logic                   start_req,
    input  logic [15:0]            payload_length,
    input  qhp_ctx_t               ctx_q,
    input  logic [LENGTH_BITS-1:0] bytes_consumed_q,
    input  logic [LENGTH_BITS-1:0] total_length_q,
    input  logic [LENGTH_BITS-1:0] private_left_q,
    output qhp_ctx_t               ctx_d,
    output logic [LENGTH_BITS-1:0] bytes_consumed_d,
    output logic [LENGTH_BITS-1:0] total_length_d,
    output logic [LENGTH_BITS-1:0] private_left_d,
    output qhp_result_t            result
);

    localparam logic [LENGTH_BITS-1:0] SERV_LEN = LENGTH_BITS'(SERVENT_ID_BYTES);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
    localparam logic [8:0]             SERV_CNT = 9'(SERVENT_ID_BYTES);
    localparam logic [7:0]             STR_MAX  = 8'(MAX_STRING_BYTES);

    qhp_ctx_t               ctx_s;
    logic [LENGTH_BITS-1:0] len_w;
    logic [LENGTH_BITS-1:0] bc_s;
    logic [LENGTH_BITS-1:0] tl_s;
    logic [LENGTH_BITS-1:0] pl_s;
    logic [LENGTH_BITS-1:0] bc_inc;
    logic [LENGTH_BITS-1:0] rem;
    logic [LENGTH_BITS-1:0] pl_dec;
    logic [LENGTH_BITS-1:0] priv_len;
    qhp_phase_t             priv_phase;
    logic [7:0]             cnt;
    logic [8:0]             cnt_inc;
    logic [31:0]            acc_new;
    logic [7:0]             hl_dec;
    logic [7:0]             odl_dec;
    logic                   done;
    logic                   msg;
    logic                   abort_str;
    logic                   past_end;
    logic                   is_fixed;
    qhp_phase_t             next_phase;
    logic [3:0]             fid;
    logic [31:0]            value;
    logic [7:0]             hitno;

    assign len_w = LENGTH_BITS'(payload_length);

    // a start byte drops any payload in progress
    always_comb begin
        if (start_req) begin
            ctx_s       = QHP_CTX_RESET;
            ctx_s.phase = (len_w == '0) ? PH_END : PH_HITS;
            bc_s        = '0;
            tl_s        = len_w;
            pl_s        = '0;
        end else begin
            ctx_s = ctx_q;
            bc_s  = bytes_consumed_q;
            tl_s  = total_length_q;
            pl_s  = private_left_q;
        end
    end

    always_comb begin
        bc_inc  = bc_s + LEN_ONE;
        rem     = (tl_s > bc_inc) ? (tl_s - bc_inc) : '0;
        cnt     = ctx_s.field_byte_count;
        cnt_inc = {1'b0, cnt} + 9'd1;
        acc_new = ctx_s.value_accumulator | (32'(payload_byte) << {cnt[1:0], 3'b000});
        hl_dec  = ctx_s.hits_left - 8'd1;
        odl_dec = ctx_s.open_data_left - 8'd1;
        pl_dec  = pl_s - LEN_ONE;
        // private data only when more than the servent id is left
        if (rem > SERV_LEN) begin
            priv_phase = PH_PRIV;
            priv_len   = rem - SERV_LEN;
        end else begin
            priv_phase = PH_SERV;
            priv_len   = '0;
        end
    end

    always_comb begin
        ctx_d            = ctx_s;
        bytes_consumed_d = bc_s;
        total_length_d   = tl_s;
        private_left_d   = pl_s;
        done             = 1'b0;
        msg              = 1'b0;
        abort_str        = 1'b0;
        past_end         = 1'b0;
        is_fixed         = 1'b0;
        next_phase       = ctx_s.phase;
        fid              = FID_HITS;
        value            = '0;
        hitno            = '0;

        case (ctx_s.phase)
            PH_HITS: begin
                fid      = FID_HITS;
                is_fixed = 1'b1;
                value    = acc_new;
                if (cnt_inc >= FW_ONE) begin
                    done            = 1'b1;
                    ctx_d.hits_left = payload_byte;
                    next_phase      = PH_PORT;
                end
            end
            PH_PORT: begin
                fid      = FID_PORT;
                is_fixed = 1'b1;
                value    = acc_new;
                if (cnt_inc >= FW_PORT) begin
                    done       = 1'b1;
                    next_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                fid      = FID_ADDR;
                is_fixed = 1'b1;
                value    = acc_new;
                if (cnt_inc >= FW_WORD) begin
                    done       = 1'b1;
                    next_phase = PH_SPEED;
                end
            end
            PH_SPEED: begin
                fid      = FID_SPEED;
                is_fixed = 1'b1;
                value    = acc_new;
                if (cnt_inc >= FW_WORD) begin
                    done       = 1'b1;
                    next_phase = (ctx_s.hits_left == 8'd0) ? PH_VENDOR : PH_INDEX;
                end
            end
            PH_INDEX: begin
                fid      = FID_INDEX;
                is_fixed = 1'b1;
                value    = acc_new;
                hitno    = ctx_s.hit_counter;
                if (cnt_inc >= FW_WORD) begin
                    done       = 1'b1;
                    next_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                fid      = FID_SIZE;
                is_fixed = 1'b1;
                value    = acc_new;
                hitno    = ctx_s.hit_counter;
                if (cnt_inc >= FW_WORD) begin
                    done       = 1'b1;
                    next_phase = PH_NAME;
                end
            end
            PH_NAME: begin
                fid   = FID_NAME;
                hitno = ctx_s.hit_counter;
                if (payload_byte == 8'd0) begin
                    done       = 1'b1;
                    next_phase = PH_EXT;
                end else if (cnt >= STR_MAX) begin
                    abort_str = 1'b1;
                end
            end
            PH_EXT: begin
                fid   = FID_EXT;
                hitno = ctx_s.hit_counter;
                if (payload_byte == 8'd0) begin
                    done              = 1'b1;
                    ctx_d.hit_counter = ctx_s.hit_counter + 8'd1;
                    ctx_d.hits_left   = hl_dec;
                    next_phase        = (hl_dec == 8'd0) ? PH_VENDOR : PH_INDEX;
                end else if (cnt >= STR_MAX) begin
                    abort_str = 1'b1;
                end
            end
            PH_VENDOR: begin
                fid      = FID_VENDOR;
                is_fixed = 1'b1;
                if (cnt_inc >= FW_WORD) begin
                    done       = 1'b1;
                    next_phase = PH_OSIZE;
                end
            end
            PH_OSIZE: begin
                fid      = FID_OSIZE;
                is_fixed = 1'b1;
                value    = acc_new;
                if (cnt_inc >= FW_ONE) begin
                    done                 = 1'b1;
                    ctx_d.open_data_left = payload_byte;
                    if (payload_byte == 8'd0) begin
                        next_phase     = priv_phase;
                        private_left_d = priv_len;
                    end else begin
                        next_phase = PH_OPEN;
                    end
                end
            end
            PH_OPEN: begin
                fid                  = FID_OPEN;
                ctx_d.open_data_left = odl_dec;
                if (odl_dec == 8'd0) begin
                    done           = 1'b1;
                    next_phase     = priv_phase;
                    private_left_d = priv_len;
                end
            end
            PH_PRIV: begin
                fid            = FID_PRIV;
                private_left_d = pl_dec;
                if (pl_dec == '0) begin
                    done       = 1'b1;
                    next_phase = PH_SERV;
                end
            end
            PH_SERV: begin
                fid = FID_SERVENT;
                if (cnt_inc >= SERV_CNT) begin
                    done       = 1'b1;
                    msg        = 1'b1;
                    next_phase = PH_END;
                end
            end
            default: begin
                // idle or stopped
                past_end = 1'b1;
            end
        endcase

        result           = '0;
        result.data_byte = payload_byte;

        if (past_end) begin
            ctx_d            = ctx_s;
            private_left_d   = pl_s;
            result.error_code = ERR_PAST_END;
        end else begin
            bytes_consumed_d = bc_inc;
            result.field_id     = fid;
            result.byte_index   = cnt;
            result.hit_number   = hitno;
            result.field_value  = value;
            result.field_done   = done;
            result.message_done = msg;
            if (abort_str) begin
                result.error_code = ERR_STR_LONG;
                next_phase        = PH_END;
            end else if (rem == '0 && !msg) begin
                result.error_code = ERR_SHORT;
                next_phase        = PH_END;
            end else begin
                result.error_code = ERR_OK;
            end
            if (done) begin
                ctx_d.field_byte_count  = 8'd0;
                ctx_d.value_accumulator = 32'd0;
            end else begin
                ctx_d.field_byte_count  = cnt_inc[7:0];
                ctx_d.value_accumulator = is_fixed ? acc_new : ctx_s.value_accumulator;
            end
            ctx_d.phase = next_phase;
        end
    end

endmodule

/* design/query_hit_payload_parser_core.sv */
// top level of the query-hit payload parser: input register, parse state, result register
`timescale 1ns / 1ps
`include "query_hit_payload_parser_core_assert.svh"

// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_payload_byte, s_start_req, s_payload_length
// m_        out        m_valid / m_ready    m_field_id .. m_error_code, one item per input item
//
// one item per cycle sustained while m_ready stays high; an accepted s_ item passes
// through the input register and then the result register before m_valid rises
// the parse step is a single pass of logic from the input register to the result register
// aresetn (synchronous, active low) clears the parse context and both valid flags
// a stall on m_ backs up through the input register, so s_ready drops while it holds an item
// s_ready is high whenever the input register is empty or moves into the result register

module query_hit_payload_parser_core import qhp_pkg::*; #(
    parameter int SERVENT_ID_BYTES = QHP_SERVENT_ID_BYTES,
    parameter int MAX_STRING_BYTES = QHP_MAX_STRING_BYTES,
    parameter int LENGTH_BITS      = QHP_LENGTH_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_start_req,
    input  logic [15:0] s_payload_length,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_field_id,
    output logic [7:0]  m_byte_index,
    output logic [7:0]  m_hit_number,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_field_value,
    output logic        m_field_done,
    output logic        m_message_done,
    output logic [1:0]  m_error_code
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [15:0] in_len_reg;

    // parse context
    qhp_ctx_t               ctx_reg;
    qhp_ctx_t               ctx_next;
    logic [LENGTH_BITS-1:0] bytes_consumed_reg;
    logic [LENGTH_BITS-1:0] bytes_consumed_next;
    logic [LENGTH_BITS-1:0] total_length_reg;
    logic [LENGTH_BITS-1:0] total_length_next;
    logic [LENGTH_BITS-1:0] private_left_reg;
    logic [LENGTH_BITS-1:0] private_left_next;

    // result register
    logic        out_valid_reg;
    qhp_result_t out_reg;
    qhp_result_t out_next;

    logic advance;
    logic s_take;

    // the held item moves on when the result register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload of the input register, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_payload_byte;
            in_start_reg <= s_start_req;
            in_len_reg   <= s_payload_length;
        end
    end

    qhp_step #(
        .SERVENT_ID_BYTES (SERVENT_ID_BYTES),
        .MAX_STRING_BYTES (MAX_STRING_BYTES),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_step (
        .payload_byte     (in_byte_reg),
        .start_req        (in_start_reg),
        .payload_length   (in_len_reg),
        .ctx_q            (ctx_reg),
        .bytes_consumed_q (bytes_consumed_reg),
        .total_length_q   (total_length_reg),
        .private_left_q   (private_left_reg),
        .ctx_d            (ctx_next),
        .bytes_consumed_d (bytes_consumed_next),
        .total_length_d   (total_length_next),
        .private_left_d   (private_left_next),
        .result           (out_next)
    );

    // parse context moves only when a byte is parsed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg            <= QHP_CTX_RESET;
            bytes_consumed_reg <= '0;
            total_length_reg   <= '0;
            private_left_reg   <= '0;
        end else if (advance) begin
            ctx_reg            <= ctx_next;
            bytes_consumed_reg <= bytes_consumed_next;
            total_length_reg   <= total_length_next;
            private_left_reg   <= private_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_field_id     = out_reg.field_id;
    assign m_byte_index   = out_reg.byte_index;
    assign m_hit_number   = out_reg.hit_number;
    assign m_data_byte    = out_reg.data_byte;
    assign m_field_value  = out_reg.field_value;
    assign m_field_done   = out_reg.field_done;
    assign m_message_done = out_reg.message_done;
    assign m_error_code   = out_reg.error_code;

    // message end only ever closes a clean servent id
    `QHP_ASSERT_IMPLY(a_msg_done_servent, aclk, aresetn, out_valid_reg && out_reg.message_done, out_reg.field_id == FID_SERVENT && out_reg.field_done && out_reg.error_code == ERR_OK, "message done outside a clean servent id")

    // a byte past the end carries nothing but its data and the error
    `QHP_ASSERT_IMPLY(a_past_end_clear, aclk, aresetn, out_valid_reg && out_reg.error_code == ERR_PAST_END, out_reg.field_id == FID_HITS && out_reg.byte_index == 8'd0 && out_reg.field_value == 32'd0 && !out_reg.field_done && !out_reg.message_done, "byte past end with field data")

    // an overlong string is only reported inside name or extension and never completes it
    `QHP_ASSERT_IMPLY(a_str_long_field, aclk, aresetn, out_valid_reg && out_reg.error_code == ERR_STR_LONG, !out_reg.field_done && (out_reg.field_id == FID_NAME || out_reg.field_id == FID_EXT), "string error outside a string field")

    // a held item that moves on shows up as a result in the next cycle
    `QHP_ASSERT_NEXT(a_item_moves, aclk, aresetn, in_valid_reg && (!out_valid_reg || m_ready), out_valid_reg, "parsed item lost before the result register")

endmodule

/* dv/tb_query_hit_payload_parser_core.sv */
// self-checking testbench of the query-hit payload parser core
`timescale 1ns / 1ps

module tb_query_hit_payload_parser_core import qhp_pkg::*; ;

    localparam int SID_BYTES    = QHP_SERVENT_ID_BYTES;
    localparam int MAX_STR      = QHP_MAX_STRING_BYTES;
    localparam int RANDOM_ITEMS = 1300;

    // one row of the directed table; fixed_exp rows carry a hand-written result
    typedef struct {
        logic [7:0]  pbyte;
        logic        start;
        logic [15:0] plen;
        bit          fixed_exp;
        qhp_result_t exp_res;
    } dir_row_t;

    // how a random payload is framed on the wire
    typedef enum {
        SHAPE_INTACT,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_CUT,
        SHAPE_TRAILING
    } shape_t;

    // receiver stall patterns
    typedef enum {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_payload_byte;
    logic        s_start_req;
    logic [15:0] s_payload_length;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_field_id;
    logic [7:0]  m_byte_index;
    logic [7:0]  m_hit_number;
    logic [7:0]  m_data_byte;
    logic [31:0] m_field_value;
    logic        m_field_done;
    logic        m_message_done;
    logic [1:0]  m_error_code;

    // hand-written expectation travelling with the item on the input channel
    logic        cur_fixed;
    qhp_result_t cur_exp;

    // parse state mirrored by the predictor
    qhp_phase_t  hp_phase;
    logic [7:0]  hp_fcnt;
    logic [7:0]  hp_hits_left;
    logic [7:0]  hp_hit_no;
    logic [31:0] hp_acc;
    logic [15:0] hp_used;
    logic [15:0] hp_total;
    logic [7:0]  hp_open_left;
    logic [15:0] hp_priv_left;

    qhp_result_t pending_fields[$];
    dir_row_t    dir_rows[$];
    logic [7:0]  msg_bytes[$];

    int       fail_count  = 0;
    int       items_sent  = 0;
    int       burst_left  = 0;
    int       rx_left     = 0;
    int       rx_hold     = 0;
    int       rx_tick     = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    always #1 aclk = ~aclk;

    query_hit_payload_parser_core #(
        .SERVENT_ID_BYTES(QHP_SERVENT_ID_BYTES),
        .MAX_STRING_BYTES(QHP_MAX_STRING_BYTES),
        .LENGTH_BITS     (QHP_LENGTH_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_start_req     (s_start_req),
        .s_payload_length(s_payload_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_field_id      (m_field_id),
        .m_byte_index    (m_byte_index),
        .m_hit_number    (m_hit_number),
        .m_data_byte     (m_data_byte),
        .m_field_value   (m_field_value),
        .m_field_done    (m_field_done),
        .m_message_done  (m_message_done),
        .m_error_code    (m_error_code)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_parse_state();
        hp_phase     = PH_IDLE;
        hp_fcnt      = 8'd0;
        hp_hits_left = 8'd0;
        hp_hit_no    = 8'd0;
        hp_acc       = 32'd0;
        hp_used      = 16'd0;
        hp_total     = 16'd0;
        hp_open_left = 8'd0;
        hp_priv_left = 16'd0;
    endfunction

    // past-end result: only the byte and the error survive
    function automatic qhp_result_t past_end(logic [7:0] b);
        qhp_result_t r;
        r = '0;
        r.data_byte  = b;
        r.error_code = ERR_PAST_END;
        return r;
    endfunction

    function automatic qhp_result_t mk_res(logic [3:0] fid, logic [7:0] idx, logic [7:0] b,
                                           logic [31:0] val, logic done, logic [1:0] err);
        qhp_result_t r;
        r = '0;
        r.field_id    = fid;
        r.byte_index  = idx;
        r.data_byte   = b;
        r.field_value = val;
        r.field_done  = done;
        r.error_code  = err;
        return r;
    endfunction

    // whatever is left beyond the servent id becomes private data
    function automatic qhp_phase_t private_or_servent(logic [15:0] rem);
        if (int'(rem) > SID_BYTES) begin
            hp_priv_left = 16'(int'(rem) - SID_BYTES);
            return PH_PRIV;
        end
        hp_priv_left = 16'd0;
        return PH_SERV;
    endfunction

    function automatic qhp_result_t parse_payload_byte(logic [7:0] b, logic st,
                                                       logic [15:0] plen);
        qhp_result_t r;
        logic [15:0] rem;
        logic [7:0]  cnt;
        qhp_phase_t  nxt;
        logic        done;
        logic        last_id;
        logic        overrun;
        int          width;
        r = '0;
        r.data_byte = b;
        if (st) begin
            clear_parse_state();
            hp_total = plen;
            hp_phase = (plen == 16'd0) ? PH_END : PH_HITS;
        end
        if (hp_phase == PH_IDLE || hp_phase == PH_END)
            return past_end(b);

        hp_used = hp_used + 16'd1;
        rem     = (hp_total > hp_used) ? hp_total - hp_used : 16'd0;
        cnt     = hp_fcnt;
        nxt     = hp_phase;
        done    = 1'b0;
        last_id = 1'b0;
        overrun = 1'b0;

        case (hp_phase)
            PH_HITS:   r.field_id = FID_HITS;
            PH_PORT:   r.field_id = FID_PORT;
            PH_ADDR:   r.field_id = FID_ADDR;
            PH_SPEED:  r.field_id = FID_SPEED;
            PH_INDEX:  r.field_id = FID_INDEX;
            PH_SIZE:   r.field_id = FID_SIZE;
            PH_NAME:   r.field_id = FID_NAME;
            PH_EXT:    r.field_id = FID_EXT;
            PH_VENDOR: r.field_id = FID_VENDOR;
            PH_OSIZE:  r.field_id = FID_OSIZE;
            PH_OPEN:   r.field_id = FID_OPEN;
            PH_PRIV:   r.field_id = FID_PRIV;
            default:   r.field_id = FID_SERVENT;
        endcase
        if (hp_phase == PH_INDEX || hp_phase == PH_SIZE || hp_phase == PH_NAME ||
            hp_phase == PH_EXT)
            r.hit_number = hp_hit_no;
        r.byte_index = cnt;

        case (hp_phase)
            PH_NAME, PH_EXT: begin
                if (b == 8'd0) begin
                    // terminator closes the string
                    done = 1'b1;
                    if (hp_phase == PH_NAME) begin
                        nxt = PH_EXT;
                    end else begin
                        hp_hit_no    = hp_hit_no + 8'd1;
                        hp_hits_left = hp_hits_left - 8'd1;
                        nxt = (hp_hits_left == 8'd0) ? PH_VENDOR : PH_INDEX;
                    end
                end else if (int'(cnt) >= MAX_STR) begin
                    overrun = 1'b1;
                end
            end
            PH_OPEN: begin
                hp_open_left = hp_open_left - 8'd1;
                if (hp_open_left == 8'd0) begin
                    done = 1'b1;
                    nxt  = private_or_servent(rem);
                end
            end
            PH_PRIV: begin
                hp_priv_left = hp_priv_left - 16'd1;
                if (hp_priv_left == 16'd0) begin
                    done = 1'b1;
                    nxt  = PH_SERV;
                end
            end
            PH_SERV: begin
                if (int'(cnt) + 1 >= SID_BYTES) begin
                    done    = 1'b1;
                    last_id = 1'b1;
                    nxt     = PH_END;
                end
            end
            default: begin
                // fixed-width little-endian fields
                hp_acc = hp_acc | (32'(b) << (8 * cnt[1:0]));
                if (hp_phase != PH_VENDOR)
                    r.field_value = hp_acc;
                if (hp_phase == PH_HITS || hp_phase == PH_OSIZE)
                    width = int'(FW_ONE);
                else if (hp_phase == PH_PORT)
                    width = int'(FW_PORT);
                else
                    width = int'(FW_WORD);
                if (int'(cnt) + 1 >= width) begin
                    done = 1'b1;
                    case (hp_phase)
                        PH_HITS: begin
                            hp_hits_left = b;
                            nxt = PH_PORT;
                        end
                        PH_PORT:   nxt = PH_ADDR;
                        PH_ADDR:   nxt = PH_SPEED;
                        PH_SPEED:  nxt = (hp_hits_left == 8'd0) ? PH_VENDOR : PH_INDEX;
                        PH_INDEX:  nxt = PH_SIZE;
                        PH_SIZE:   nxt = PH_NAME;
                        PH_VENDOR: nxt = PH_OSIZE;
                        default: begin
                            hp_open_left = b;
                            nxt = (b == 8'd0) ? private_or_servent(rem) : PH_OPEN;
                        end
                    endcase
                end
            end
        endcase

        r.field_done   = done;
        r.message_done = last_id;
        if (overrun) begin
            r.error_code = ERR_STR_LONG;
            nxt  = PH_END;
            done = 1'b0;
        end else if (rem == 16'd0 && !last_id) begin
            r.error_code = ERR_SHORT;
            nxt = PH_END;
        end

        if (done) begin
            hp_fcnt = 8'd0;
            hp_acc  = 32'd0;
        end else begin
            hp_fcnt = cnt + 8'd1;
        end
        hp_phase = nxt;
        return r;
    endfunction

    function automatic string res_str(qhp_result_t r);
        return $sformatf("fid=%0d idx=%0d hit=%0d data=%02h val=%08h done=%0b msg=%0b err=%0d",
                         r.field_id, r.byte_index, r.hit_number, r.data_byte, r.field_value,
                         r.field_done, r.message_done, r.error_code);
    endfunction

    // ------------------------------------------------------------------
    // checking: predict on input acceptance, compare on output acceptance
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        qhp_result_t predicted;
        qhp_result_t got;
        qhp_result_t want;
        if (aresetn && s_valid && s_ready) begin
            // the predictor runs on every item so its state stays in step
            predicted = parse_payload_byte(s_payload_byte, s_start_req, s_payload_length);
            pending_fields.push_back(cur_fixed ? cur_exp : predicted);
        end
        if (aresetn && m_valid && m_ready) begin
            got.field_id     = m_field_id;
            got.byte_index   = m_byte_index;
            got.hit_number   = m_hit_number;
            got.data_byte    = m_data_byte;
            got.field_value  = m_field_value;
            got.field_done   = m_field_done;
            got.message_done = m_message_done;
            got.error_code   = m_error_code;
            if (pending_fields.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: %s", res_str(got));
            end else begin
                want = pending_fields.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", res_str(want));
                        $display("  actual   %s", res_str(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: a randomly switched stall pattern sets m_ready on all cycles
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_ready <= (rx_tick % 4 != 0);
            default: begin
                // long stalls now and then
                if (rx_hold > 0) begin
                    m_ready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_hold <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // present one item, holding it until accepted; bursts with random gaps
    task automatic send_item(input logic [7:0] b, input logic st, input logic [15:0] plen,
                             input bit fx, input qhp_result_t ex);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_payload_byte   <= b;
        s_start_req      <= st;
        s_payload_length <= plen;
        cur_fixed        <= fx;
        cur_exp          <= ex;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic void push_random_bytes(int n);
        repeat (n) msg_bytes.push_back(8'($urandom));
    endfunction

    // string of n nonzero characters, zero-terminated when asked
    function automatic void push_text(int n, bit terminated);
        repeat (n) msg_bytes.push_back(8'($urandom_range(1, 255)));
        if (terminated)
            msg_bytes.push_back(8'h00);
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        int     msg_no;
        int     n_hits;
        int     open_len;
        int     body_len;
        int     decl_len;
        int     n_send;
        int     extra;
        bit     long_name;
        bit     overrun;
        shape_t shape;

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_payload_byte   <= 8'd0;
        s_start_req      <= 1'b0;
        s_payload_length <= 16'd0;
        m_ready          <= 1'b0;
        cur_fixed        <= 1'b0;
        cur_exp          <= '0;
        clear_parse_state();

        // directed table: errors out of reset, zero length, extremes, restarts
        dir_rows.push_back('{8'h5A, 1'b0, 16'h0000, 1'b1, past_end(8'h5A)});
        dir_rows.push_back('{8'hFF, 1'b1, 16'h0000, 1'b1, past_end(8'hFF)});
        dir_rows.push_back('{8'h00, 1'b1, 16'h0001, 1'b1,
                             mk_res(FID_HITS, 8'd0, 8'h00, 32'h0, 1'b1, ERR_SHORT)});
        dir_rows.push_back('{8'hFF, 1'b0, 16'hFFFF, 1'b1, past_end(8'hFF)});
        dir_rows.push_back('{8'hFF, 1'b1, 16'hFFFF, 1'b1,
                             mk_res(FID_HITS, 8'd0, 8'hFF, 32'hFF, 1'b1, ERR_OK)});
        dir_rows.push_back('{8'h00, 1'b0, 16'h0000, 1'b1,
                             mk_res(FID_PORT, 8'd0, 8'h00, 32'h0, 1'b0, ERR_OK)});
        dir_rows.push_back('{8'hFF, 1'b0, 16'hFFFF, 1'b1,
                             mk_res(FID_PORT, 8'd1, 8'hFF, 32'h0000FF00, 1'b1, ERR_OK)});
        dir_rows.push_back('{8'hFF, 1'b0, 16'h8000, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 16'h7FFF, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 16'hFFFF, 1'b0, '0});
        // restart mid-payload with no hits, cut short on the last speed byte
        dir_rows.push_back('{8'h00, 1'b1, 16'd11, 1'b0, '0});
        dir_rows.push_back('{8'h34, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h12, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h02, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h03, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h04, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, 16'h0000, 1'b0, '0});
        dir_rows.push_back('{8'h77, 1'b0, 16'h0000, 1'b1, past_end(8'h77)});
        // too short inside a multi-byte field
        dir_rows.push_back('{8'h03, 1'b1, 16'd2, 1'b0, '0});
        dir_rows.push_back('{8'h80, 1'b0, 16'hFFFF, 1'b0, '0});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].pbyte, dir_rows[i].start, dir_rows[i].plen,
                      dir_rows[i].fixed_exp, dir_rows[i].exp_res);

        // random payloads: mostly well formed, some mis-framed, plus line noise
        items_sent = 0;
        msg_no     = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom), ($urandom_range(0, 2) == 0),
                              ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                              1'b0, '0);
            end

            // one payload gets a full-length name and private data past 256 bytes,
            // another overruns the extension string
            long_name = (msg_no == 1);
            overrun   = (msg_no == 3);
            n_hits    = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
            if ((long_name || overrun) && n_hits == 0)
                n_hits = 1;

            msg_bytes.delete();
            msg_bytes.push_back(8'(n_hits));
            push_random_bytes(10);                     // port, address, speed
            for (int h = 0; h < n_hits; h++) begin
                push_random_bytes(8);                  // index, size
                push_text((long_name && h == 0) ? MAX_STR : $urandom_range(0, 10), 1'b1);
                if (overrun && h == n_hits - 1)
                    push_text(MAX_STR + 1, 1'b0);
                else
                    push_text($urandom_range(0, 4), 1'b1);
            end
            push_random_bytes(4);                      // vendor code
            open_len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 255)
                                                    : $urandom_range(0, 6);
            msg_bytes.push_back(8'(open_len));
            push_random_bytes(open_len);
            push_random_bytes(long_name ? 270 : $urandom_range(0, 12));
            push_random_bytes(SID_BYTES);
            body_len = msg_bytes.size();

            if (long_name || overrun) begin
                shape = SHAPE_INTACT;
            end else begin
                case ($urandom_range(0, 9))
                    6:       shape = SHAPE_SHORT;
                    7:       shape = SHAPE_LONG;
                    8:       shape = SHAPE_CUT;
                    9:       shape = SHAPE_TRAILING;
                    default: shape = SHAPE_INTACT;
                endcase
            end

            decl_len = body_len;
            n_send   = body_len;
            case (shape)
                SHAPE_SHORT: begin
                    // declared length falls inside the payload
                    decl_len = $urandom_range(1, body_len - 1);
                    extra    = $urandom_range(0, 3);
                    n_send   = (decl_len + extra > body_len) ? body_len : decl_len + extra;
                end
                SHAPE_LONG: decl_len = body_len + $urandom_range(1, 40);
                SHAPE_CUT:  n_send = $urandom_range(1, body_len - 1);
                SHAPE_TRAILING: begin
                    extra = $urandom_range(1, 3);
                    push_random_bytes(extra);
                    n_send = body_len + extra;
                end
                default: ;
            endcase

            for (int i = 0; i < n_send; i++)
                send_item(msg_bytes[i], (i == 0), (i == 0) ? 16'(decl_len) : 16'($urandom),
                          1'b0, '0);
            msg_no++;
        end

        s_valid <= 1'b0;
        // wait for the last accepted item to be queued for checking
        @(posedge aclk);
        while (pending_fields.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #500000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/qhp_pkg.sv
design/qhp_step.sv
design/query_hit_payload_parser_core.sv
dv/tb_query_hit_payload_parser_core.sv
